// ===== src/sbmq_pkg.sv =====
package sbmq_pkg;

  // Fixed field widths of the stream payload
  localparam int WORD_W = 32;
  localparam int QID_W  = 3;

  // Word returned by a dequeue from an empty queue
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // Outcome of one request, handed from the pointer logic to the result stage
  typedef struct packed {
    status_t status;
    logic    deq;
  } result_t;

endpackage

// ===== src/sbmq_ram.sv =====
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sbmq_ctrl.sv =====
module sbmq_ctrl import sbmq_pkg::*; #(
  parameter int NUM_QUEUES = 8,
  parameter int NUM_SLOTS  = 16,
  localparam int AW = $clog2(NUM_SLOTS),
  localparam int PW = $clog2(NUM_SLOTS + 1),
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  req_t             req,
  input  logic [QID_W-1:0] queue_id,
  input  logic [PW-1:0]    link_rdata,
  output logic             link_re,
  output logic [AW-1:0]    link_raddr,
  output logic             link_we,
  output logic [AW-1:0]    link_waddr,
  output logic [PW-1:0]    link_wdata,
  output logic             data_we,
  output logic [AW-1:0]    data_waddr,
  output logic             data_re,
  output logic [AW-1:0]    data_raddr,
  output result_t          result
);

  localparam logic [PW-1:0] PTR_NULL = PW'(NUM_SLOTS);

  // Pointer registers; a queue's head and tail mean something only while it is busy
  logic [PW-1:0]         free_r, free_nxt;
  logic [AW-1:0]         head_r [NUM_QUEUES];
  logic [AW-1:0]         head_nxt [NUM_QUEUES];
  logic [AW-1:0]         tail_r [NUM_QUEUES];
  logic [AW-1:0]         tail_nxt [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] busy_r, busy_nxt;

  // A pointer whose new value is the link read issued in the previous cycle
  logic                  pend_free_r, pend_free_nxt;
  logic                  pend_head_r, pend_head_nxt;
  logic [QW-1:0]         pend_q_r, pend_q_nxt;

  logic          q_ok;
  logic [QW-1:0] q_idx;
  logic [PW-1:0] eff_free;
  logic [AW-1:0] eff_head;
  logic [AW-1:0] q_tail;
  logic          q_busy;
  logic          free_ok;

  assign q_ok     = 32'(queue_id) < 32'(NUM_QUEUES);
  assign q_idx    = QW'(queue_id);
  assign eff_free = pend_free_r ? link_rdata : free_r;
  assign eff_head = (pend_head_r && pend_q_r == q_idx) ? link_rdata[AW-1:0]
                                                       : head_r[q_idx];
  assign q_tail   = tail_r[q_idx];
  assign q_busy   = busy_r[q_idx];
  assign free_ok  = eff_free != PTR_NULL;

  // Decide the request, drive the link and data stores, update pointers
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    busy_nxt      = busy_r;
    free_nxt      = free_r;
    pend_free_nxt = 1'b0;
    pend_head_nxt = 1'b0;
    pend_q_nxt    = pend_q_r;

    // commit last cycle's link read first; this request overrides it
    if (pend_free_r) begin
      free_nxt = link_rdata;
    end
    if (pend_head_r) begin
      head_nxt[pend_q_r] = link_rdata[AW-1:0];
    end

    link_re       = 1'b0;
    link_raddr    = '0;
    link_we       = 1'b0;
    link_waddr    = '0;
    link_wdata    = '0;
    data_we       = 1'b0;
    data_waddr    = '0;
    data_re       = 1'b0;
    data_raddr    = '0;
    result.status = ST_OK;
    result.deq    = (req == REQ_DEQ);

    if (req == REQ_ENQ) begin
      if (!(q_ok && free_ok)) begin
        result.status = ST_OVERFLOW;
      end else if (fire) begin
        // take the free head, store the word, link it behind the tail
        data_we    = 1'b1;
        data_waddr = eff_free[AW-1:0];
        link_re    = 1'b1;
        link_raddr = eff_free[AW-1:0];
        if (q_busy) begin
          link_we    = 1'b1;
          link_waddr = q_tail;
          link_wdata = eff_free;
        end else begin
          head_nxt[q_idx] = eff_free[AW-1:0];
        end
        tail_nxt[q_idx] = eff_free[AW-1:0];
        busy_nxt[q_idx] = 1'b1;
        pend_free_nxt   = 1'b1;
      end
    end else begin
      if (!(q_ok && q_busy)) begin
        result.status = ST_EMPTY;
      end else if (fire) begin
        // unlink the head slot and push it onto the free list
        data_re    = 1'b1;
        data_raddr = eff_head;
        link_re    = 1'b1;
        link_raddr = eff_head;
        link_we    = 1'b1;
        link_waddr = eff_head;
        link_wdata = eff_free;
        free_nxt   = PW'(eff_head);
        if (eff_head == q_tail) begin
          busy_nxt[q_idx] = 1'b0;
        end else begin
          pend_head_nxt = 1'b1;
          pend_q_nxt    = q_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      busy_r      <= '0;
      pend_free_r <= 1'b0;
      pend_head_r <= 1'b0;
    end else begin
      free_r      <= free_nxt;
      busy_r      <= busy_nxt;
      pend_free_r <= pend_free_nxt;
      pend_head_r <= pend_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    pend_q_r <= pend_q_nxt;
  end

endmodule

// ===== src/shared_buffer_multi_queue.sv =====
// Channel  Dir  Ports                              Content
// in       in   in_tvalid in_tready in_tdata/tuser   one request beat
// out      out  out_tvalid out_tready out_tdata/tuser one result beat per request
//
// One request beat is taken every cycle while no result is stalled; its result
// passes the input register, then the result stage behind the store reads.
// The sustained rate is set by the read of the link store, whose
// data is forwarded straight into the free and queue head pointers.
// After reset the link store is initialized one slot a cycle, with in_tready
// held low. A stalled result holds the whole pipeline.
module shared_buffer_multi_queue import sbmq_pkg::*; #(
  parameter int NUM_QUEUES = 8,
  parameter int NUM_SLOTS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value_in[31:0]
  input  logic [3:0]  in_tuser,   // req_type[0], queue_id[3:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_out[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);

  // Link store initialization
  logic          init_done_r;
  logic [AW-1:0] init_cnt_r;

  // Input register
  logic             s1_valid_r;
  req_t             s1_req_r;
  logic [QID_W-1:0] s1_qid_r;
  logic [31:0]      s1_value_r;
  logic             s1_fire;

  // Result stage
  logic    r2_valid_r;
  result_t r2_result_r;

  // Store ports
  logic            c_link_re, c_link_we, c_data_we, c_data_re;
  logic [AW-1:0]   c_link_raddr, c_link_waddr, c_data_waddr, c_data_raddr;
  logic [PW-1:0]   c_link_wdata, link_rdata;
  logic            link_we;
  logic [AW-1:0]   link_waddr;
  logic [PW-1:0]   link_wdata;
  logic [DATA_WIDTH-1:0] data_rdata;
  result_t         c_result;

  assign s1_fire   = s1_valid_r && (!r2_valid_r || out_tready);
  assign in_tready = init_done_r && (!s1_valid_r || s1_fire);

  // Walk the link store once after reset: slot i links to i+1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
      init_cnt_r  <= '0;
    end else if (!init_done_r) begin
      init_cnt_r <= init_cnt_r + AW'(1);
      if (init_cnt_r == AW'(NUM_SLOTS - 1)) begin
        init_done_r <= 1'b1;
      end
    end
  end

  assign link_we    = init_done_r ? c_link_we : 1'b1;
  assign link_waddr = init_done_r ? c_link_waddr : init_cnt_r;
  assign link_wdata = init_done_r ? c_link_wdata : PW'(init_cnt_r) + PW'(1);

  // Capture a request beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r   <= req_t'(in_tuser[0]);
      s1_qid_r   <= in_tuser[3:1];
      s1_value_r <= in_tdata;
    end
  end

  sbmq_ctrl #(
    .NUM_QUEUES (NUM_QUEUES),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .req        (s1_req_r),
    .queue_id   (s1_qid_r),
    .link_rdata (link_rdata),
    .link_re    (c_link_re),
    .link_raddr (c_link_raddr),
    .link_we    (c_link_we),
    .link_waddr (c_link_waddr),
    .link_wdata (c_link_wdata),
    .data_we    (c_data_we),
    .data_waddr (c_data_waddr),
    .data_re    (c_data_re),
    .data_raddr (c_data_raddr),
    .result     (c_result)
  );

  sbmq_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (c_link_re),
    .raddr (c_link_raddr),
    .rdata (link_rdata)
  );

  sbmq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (c_data_we),
    .waddr (c_data_waddr),
    .wdata (DATA_WIDTH'(s1_value_r)),
    .re    (c_data_re),
    .raddr (c_data_raddr),
    .rdata (data_rdata)
  );

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_valid_r <= 1'b0;
    end else if (s1_fire) begin
      r2_valid_r <= 1'b1;
    end else if (out_tready) begin
      r2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      r2_result_r <= c_result;
    end
  end

  // The data store read stays put until the next dequeue fires
  assign out_tvalid = r2_valid_r;
  assign out_tuser  = r2_result_r.status;
  always_comb begin
    case (r2_result_r.status)
      ST_OK:    out_tdata = r2_result_r.deq ? 32'(data_rdata) : '0;
      ST_EMPTY: out_tdata = EMPTY_WORD;
      default:  out_tdata = '0;
    endcase
  end

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done_r |-> !in_tready)
    else $error("request taken during link store initialization");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> r2_valid_r)
    else $error("fired request produced no result");

  a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_qid_r))
    else $error("stalled request lost");

  a_overflow_is_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
    r2_valid_r && r2_result_r.status == ST_OVERFLOW |-> !r2_result_r.deq)
    else $error("overflow reported on a dequeue");

endmodule
